/* design/asq_pkg.sv */
// ----------------------------------------------------------------------------
// asq_pkg: shared definitions for the A/D scan sequencer
// Widths, register indexes, event kinds and reset values of the sequencer.
// ----------------------------------------------------------------------------
package asq_pkg;

    localparam int NUM_SENSORS = 5;
    localparam int RESULT_BITS = 10;

    // Field widths of the stream items
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 10;
    localparam int CHAN_W    = 4;
    localparam int SEL_W     = 3;
    localparam int READING_W = 10;
    localparam int PERIOD_W  = 8;
    localparam int IDX_W     = $clog2(NUM_SENSORS + 1);

    // Packed stream widths, rounded up to whole bytes
    localparam int S_FIELDS_W = VALUE_W + CHAN_W + SEL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + CHAN_W + 1 + READING_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = PERIOD_W;

    localparam logic [CFG_ADDR_W-1:0] REG_TICK_PERIOD = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_BASE   = CFG_ADDR_W'(1);

    // Reset values
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = PERIOD_W'(100);
    localparam logic [CHAN_W-1:0] CHAN_RESET [NUM_SENSORS] =
        '{4'h1, 4'h3, 4'h4, 4'h8, 4'h9};

    // Event kinds carried in tuser; the unused code acts as no event
    typedef enum logic [KIND_W-1:0] {
        EV_TICK = 2'd0,
        EV_DONE = 2'd1,
        EV_NONE = 2'd2
    } event_kind_t;

endpackage

/* design/adc_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// adc_scan_sequencer: periodic A/D scan sequencer
// Tick-driven scan of five converter channels with per-slot result storage.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one event per item. tuser carries the event kind
//   (tick, conversion complete, no event); tdata carries the converter
//   value, the channel it was taken on and the slot to read back.
//   Master stream (m_*): exactly one result per input item, in order:
//   start request, channel to convert, busy flag and the selected reading.
//   Config port: write cfg_wdata to register cfg_addr when cfg_wr_en is
//   high (0 tick period, 1..5 channel of sensor slot 0..4). Write only
//   while no item is in flight.
// Pipeline:
//   An item is registered on accept in the input register, processed by
//   one stage of compare, match and mux logic, and registered in the
//   output register, whose contents appear on m_*.
//   One item per cycle is sustained while m_tready is high; the input register
//   and the output register each free up in the cycle their item moves on.
// Reset (aresetn low, synchronous): both streams empty, counter, index and
//   busy flag clear, all readings zero, config registers to defaults.
// Stall: with m_tready low the result holds, the input register fills,
//   and s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module adc_scan_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [asq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [asq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata, low bit up: conversion_value[9:0], conversion_channel[3:0],
    //   read_sensor[2:0], zero pad
    input  logic [asq_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: event_kind[1:0]
    input  logic [asq_pkg::KIND_W-1:0]     s_tuser,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata, low bit up: start_conversion, start_channel[3:0], scan_busy,
    //   reading[9:0]
    output logic [asq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import asq_pkg::*;

    // Configuration registers
    logic [PERIOD_W-1:0] tick_period_reg;
    logic [CHAN_W-1:0]   chan_reg [NUM_SENSORS];

    // Input register
    logic                in_vld_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [VALUE_W-1:0]  in_value_reg;
    logic [CHAN_W-1:0]   in_chan_reg;
    logic [SEL_W-1:0]    in_sel_reg;

    // Sequencer state
    logic [PERIOD_W-1:0]    tick_count_reg, tick_count_next;
    logic [IDX_W-1:0]       sensor_index_reg, sensor_index_next;
    logic                   scan_waiting_reg, scan_waiting_next;
    logic [RESULT_BITS-1:0] readings_reg [NUM_SENSORS];

    // Output register
    logic                 out_vld_reg;
    logic                 out_start_reg, out_start_next;
    logic [CHAN_W-1:0]    out_chan_reg, out_chan_next;
    logic                 out_busy_reg;
    logic [READING_W-1:0] out_reading_reg, out_reading_next;

    // Step logic
    logic                   advance;
    logic                   out_free;
    logic                   do_advance;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_slot;
    logic [CHAN_W-1:0]      idx_chan;
    logic [RESULT_BITS-1:0] wr_value;

    // Handshake: the input register moves on whenever the output is free
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'({out_reading_reg, out_busy_reg,
                                  out_chan_reg, out_start_reg});

    assign wr_value = RESULT_BITS'(in_value_reg);

    // Slot of the finished conversion: lowest match among slots 1..4, else 0
    always_comb begin
        wr_slot = '0;
        for (int k = NUM_SENSORS - 1; k >= 1; k--) begin
            if (chan_reg[k] == in_chan_reg) begin
                wr_slot = IDX_W'(k);
            end
        end
    end

    // Channel of the sensor the scan points at
    always_comb begin
        idx_chan = '0;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            if (sensor_index_reg == IDX_W'(k)) begin
                idx_chan = chan_reg[k];
            end
        end
    end

    // Event handling: tick counter, completion store, scan advance
    always_comb begin
        tick_count_next   = tick_count_reg;
        sensor_index_next = sensor_index_reg;
        scan_waiting_next = scan_waiting_reg;
        out_start_next    = 1'b0;
        out_chan_next     = '0;
        do_advance        = 1'b0;
        wr_en             = 1'b0;
        case (event_kind_t'(in_kind_reg))
            EV_TICK: begin
                if (tick_count_reg > tick_period_reg) begin
                    do_advance      = !scan_waiting_reg;
                    tick_count_next = PERIOD_W'(1);
                end else begin
                    tick_count_next = tick_count_reg + PERIOD_W'(1);
                end
            end
            EV_DONE: begin
                wr_en      = 1'b1;
                do_advance = 1'b1;
            end
            default: begin
            end
        endcase
        if (do_advance) begin
            if (sensor_index_reg >= IDX_W'(NUM_SENSORS)) begin
                // last sensor done: go idle
                scan_waiting_next = 1'b0;
                sensor_index_next = '0;
            end else begin
                out_start_next    = 1'b1;
                out_chan_next     = idx_chan;
                sensor_index_next = sensor_index_reg + IDX_W'(1);
                scan_waiting_next = 1'b1;
            end
        end
    end

    // Read back the selected slot as it stands after this item
    always_comb begin
        out_reading_next = '0;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            if (in_sel_reg == SEL_W'(k)) begin
                if (wr_en && wr_slot == IDX_W'(k)) begin
                    out_reading_next = READING_W'(wr_value);
                end else begin
                    out_reading_next = READING_W'(readings_reg[k]);
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_PERIOD_RESET;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                chan_reg[k] <= CHAN_RESET[k];
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_TICK_PERIOD) begin
                tick_period_reg <= cfg_wdata;
            end
            for (int k = 0; k < NUM_SENSORS; k++) begin
                if (cfg_addr == REG_CHAN_BASE + CFG_ADDR_W'(k)) begin
                    chan_reg[k] <= CHAN_W'(cfg_wdata);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_value_reg <= s_tdata[VALUE_W-1:0];
            in_chan_reg  <= s_tdata[VALUE_W +: CHAN_W];
            in_sel_reg   <= s_tdata[VALUE_W + CHAN_W +: SEL_W];
        end
    end

    // Sequencer state, committed as the item moves to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg   <= '0;
            sensor_index_reg <= '0;
            scan_waiting_reg <= 1'b0;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                readings_reg[k] <= '0;
            end
        end else if (advance) begin
            tick_count_reg   <= tick_count_next;
            sensor_index_reg <= sensor_index_next;
            scan_waiting_reg <= scan_waiting_next;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                if (wr_en && wr_slot == IDX_W'(k)) begin
                    readings_reg[k] <= wr_value;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
        if (advance) begin
            out_start_reg   <= out_start_next;
            out_chan_reg    <= out_chan_next;
            out_busy_reg    <= scan_waiting_next;
            out_reading_reg <= out_reading_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // idle scan always sits at sensor 0
    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        !scan_waiting_reg |-> sensor_index_reg == '0)
        else $error("scan idle with nonzero sensor index");

    // a busy scan points past a requested sensor, never beyond the last
    a_busy_index: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_waiting_reg |-> (sensor_index_reg != '0 &&
                              sensor_index_reg <= IDX_W'(NUM_SENSORS)))
        else $error("busy scan with bad sensor index");

    // a start request always leaves the scan busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_start_reg) |-> out_busy_reg)
        else $error("conversion requested while scan idle");

    // channel field is zero without a start request
    a_chan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_start_reg) |-> out_chan_reg == '0)
        else $error("start channel set without start request");

endmodule
